// ===== rtl/core/swg_pkg.sv =====
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types and constants of the shift/xor word generator.
// ----------------------------------------------------------------------------
package swg_pkg;

    localparam int WORD_W   = 32;
    localparam int MID_W    = 10;
    localparam int SHIFT_W  = 5;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W  = 3;

    localparam logic [WORD_W-1:0]  SEED_MULT  = 32'd31415;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 3'd1;
    localparam logic [COUNT_W-1:0] COUNT_FOUR = 3'd4;

    typedef enum logic [1:0] {
        MODE_SEED    = 2'd0,
        MODE_NEXT32  = 2'd1,
        MODE_NEXT128 = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MID_OFFSET  = 3'd0,
        CFG_SHIFT_A     = 3'd1,
        CFG_SHIFT_B     = 3'd2,
        CFG_RIGHT_SHIFT = 3'd3,
        CFG_LEFT_SHIFT  = 3'd4
    } cfg_idx_t;

    // controller -> datapath
    typedef struct packed {
        logic start;       // latch transaction inputs
        logic sweep_wr;    // write one sweep word (ring entry or carry)
        logic sweep_zero;  // sweep writes zero (clearing pass)
        logic pos_zero;    // position back to zero
        logic out_rd;      // read a pair of output words
        logic cap_lo;      // capture words 0 and 1
        logic cap_hi;      // capture words 2 and 3
        logic step_rd;     // issue reads of one recurrence step
        logic step_wr;     // compute and write back one recurrence step
        logic cap_x;       // capture the slot word as single result
        logic out_load;    // move captured words to the output register
    } swg_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mid_busy;    // mid_offset reduction still running
        logic sweep_last;  // sweep index points at the carry word
    } swg_status_t;

endpackage

// ===== rtl/core/swg_ctrl.sv =====
// ----------------------------------------------------------------------------
// swg_ctrl
// Sequencer: clearing pass, seed sweep, output reads, recurrence steps and
// the output handshake.
// ----------------------------------------------------------------------------
module swg_ctrl
    import swg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    output logic        out_valid,
    input  logic        out_ready,
    input  swg_status_t status,
    output swg_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_OUT_RD0,
        ST_OUT_RD1,
        ST_STEPS,
        ST_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic        four_reg, four_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  step_total;
    logic        out_free;

    assign step_total = four_reg ? 3'd4 : 3'd1;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign in_ready   = (state_reg == ST_IDLE) && !status.mid_busy;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        four_next  = four_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_wr   = 1'b1;
                cmd.sweep_zero = 1'b1;
                if (status.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.start = 1'b1;
                    cnt_next  = 3'd0;
                    case (mode)
                        MODE_SEED:
                            state_next = ST_SWEEP;
                        MODE_NEXT32:
                        begin
                            four_next  = 1'b0;
                            state_next = ST_STEPS;
                        end
                        MODE_NEXT128:
                        begin
                            four_next  = 1'b1;
                            state_next = ST_OUT_RD0;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.pos_zero = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_OUT_RD0:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT_RD1;
            end
            ST_OUT_RD1:
            begin
                cmd.out_rd = 1'b1;
                cmd.cap_lo = 1'b1;
                state_next = ST_STEPS;
            end
            ST_STEPS:
            begin
                // reads of step k overlap the write-back of step k-1
                cmd.step_rd = (cnt_reg < step_total);
                cmd.step_wr = (cnt_reg != 3'd0);
                cmd.cap_hi  = four_reg && (cnt_reg == 3'd0);
                cmd.cap_x   = !four_reg && (cnt_reg == 3'd1);
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == step_total)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            four_reg      <= 1'b0;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            four_reg      <= four_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/swg_datapath.sv =====
// ----------------------------------------------------------------------------
// swg_datapath
// Ring memory, carry and position, configuration registers, recurrence
// step logic, seed sweep and the output register.
// ----------------------------------------------------------------------------
module swg_datapath
    import swg_pkg::*;
#(
    parameter int RING_WORDS = 624
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [WORD_W-1:0]    seed,
    input  logic [1:0]           word_offset,
    input  swg_cmd_t             cmd,
    output swg_status_t          status,
    output logic [WORD_W-1:0]    word0,
    output logic [WORD_W-1:0]    word1,
    output logic [WORD_W-1:0]    word2,
    output logic [WORD_W-1:0]    word3,
    output logic [COUNT_W-1:0]   word_count
);

    localparam int AW = $clog2(RING_WORDS);
    localparam int CW = $clog2(RING_WORDS + 1);
    localparam logic [AW:0]      RING_N     = (AW + 1)'(RING_WORDS);
    localparam logic [AW:0]      ONE_A      = (AW + 1)'(1);
    localparam logic [AW:0]      TWO_A      = (AW + 1)'(2);
    localparam logic [CW-1:0]    SWEEP_END  = CW'(RING_WORDS);
    localparam logic [CW-1:0]    ONE_C      = CW'(1);
    localparam logic [MID_W:0]   MID_LIMIT  = (MID_W + 1)'(RING_WORDS);

    function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] v);
        logic [AW:0] d;
        d = v - RING_N;
        return (v >= RING_N) ? d[AW-1:0] : v[AW-1:0];
    endfunction

    // configuration
    logic [MID_W-1:0]   mid_red_reg;
    logic [SHIFT_W-1:0] shift_a_reg, shift_b_reg, right_shift_reg, left_shift_reg;
    logic [MID_W:0]     mid_sub;

    // state
    logic [WORD_W-1:0]  ring_mem [RING_WORDS];
    logic [WORD_W-1:0]  carry_reg;
    logic [AW-1:0]      position_reg;

    // sequencing
    logic [CW-1:0]      sweep_idx_reg;
    logic [WORD_W-1:0]  s_reg;
    logic [AW-1:0]      slot_reg;
    logic [AW-1:0]      out_addr_reg;

    // read pipeline
    logic [AW-1:0]      rd_addr_a, rd_addr_b;
    logic [AW-1:0]      rd_a_addr_reg, rd_b_addr_reg;
    logic [WORD_W-1:0]  rdata_a_reg, rdata_b_reg;
    logic               fwd_valid_reg;
    logic [AW-1:0]      fwd_addr_reg;
    logic [WORD_W-1:0]  fwd_data_reg;

    // capture and output
    logic [WORD_W-1:0]  cap_reg [4];
    logic [COUNT_W-1:0] cap_count_reg;
    logic [WORD_W-1:0]  word_reg [4];
    logic [COUNT_W-1:0] count_reg;

    logic               sweep_last;
    logic [WORD_W-1:0]  sweep_word;
    logic [AW-1:0]      other_idx, out_addr_inc, out_addr_adv, start_addr;
    logic [WORD_W-1:0]  x_word, y_word, u0, u1, step_new;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    assign mid_sub    = {1'b0, mid_red_reg} - MID_LIMIT;
    assign sweep_last = (sweep_idx_reg == SWEEP_END);
    assign sweep_word = s_reg + WORD_W'(sweep_idx_reg);

    assign status.mid_busy   = ({1'b0, mid_red_reg} >= MID_LIMIT);
    assign status.sweep_last = sweep_last;

    assign other_idx    = wrap_idx({1'b0, slot_reg} + {1'b0, mid_red_reg[AW-1:0]});
    assign out_addr_inc = wrap_idx({1'b0, out_addr_reg} + ONE_A);
    assign out_addr_adv = wrap_idx({1'b0, out_addr_reg} + TWO_A);
    assign start_addr   = wrap_idx({1'b0, position_reg} + (AW + 1)'(word_offset));

    assign rd_addr_a = cmd.step_rd ? slot_reg  : out_addr_reg;
    assign rd_addr_b = cmd.step_rd ? other_idx : out_addr_inc;

    // write of the previous step lands in the cycle its successor is read
    assign x_word = (fwd_valid_reg && (fwd_addr_reg == rd_a_addr_reg)) ?
                    fwd_data_reg : rdata_a_reg;
    assign y_word = (fwd_valid_reg && (fwd_addr_reg == rd_b_addr_reg)) ?
                    fwd_data_reg : rdata_b_reg;

    assign u0       = carry_reg ^ (x_word >> right_shift_reg) ^
                      (x_word << left_shift_reg) ^ y_word;
    assign u1       = u0 ^ (u0 << shift_a_reg);
    assign step_new = x_word ^ u1 ^ (u1 << shift_b_reg);

    always_comb
    begin
        mem_we    = cmd.step_wr || (cmd.sweep_wr && !sweep_last);
        mem_waddr = cmd.step_wr ? rd_a_addr_reg : sweep_idx_reg[AW-1:0];
        if (cmd.step_wr)
            mem_wdata = step_new;
        else if (cmd.sweep_zero)
            mem_wdata = '0;
        else
            mem_wdata = sweep_word;
    end

    // ring memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
        rdata_a_reg <= ring_mem[rd_addr_a];
        rdata_b_reg <= ring_mem[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_red_reg     <= MID_W'(1);
            shift_a_reg     <= SHIFT_W'(1);
            shift_b_reg     <= SHIFT_W'(1);
            right_shift_reg <= SHIFT_W'(1);
            left_shift_reg  <= SHIFT_W'(1);
            carry_reg       <= '0;
            position_reg    <= '0;
            sweep_idx_reg   <= '0;
            fwd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MID_OFFSET:  mid_red_reg     <= cfg_data[MID_W-1:0];
                    CFG_SHIFT_A:     shift_a_reg     <= cfg_data[SHIFT_W-1:0];
                    CFG_SHIFT_B:     shift_b_reg     <= cfg_data[SHIFT_W-1:0];
                    CFG_RIGHT_SHIFT: right_shift_reg <= cfg_data[SHIFT_W-1:0];
                    CFG_LEFT_SHIFT:  left_shift_reg  <= cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end
            if (status.mid_busy && !(cfg_wr_en && (cfg_index == CFG_MID_OFFSET)))
                mid_red_reg <= mid_sub[MID_W-1:0];

            if (cmd.step_wr)
                carry_reg <= u1;
            else if (cmd.sweep_wr && sweep_last)
                carry_reg <= cmd.sweep_zero ? '0 : sweep_word;

            if (cmd.step_wr)
                position_reg <= wrap_idx({1'b0, rd_a_addr_reg} + ONE_A);
            else if (cmd.pos_zero)
                position_reg <= '0;

            if (cmd.start)
                sweep_idx_reg <= '0;
            else if (cmd.sweep_wr)
                sweep_idx_reg <= sweep_idx_reg + ONE_C;

            fwd_valid_reg <= cmd.step_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_addr_reg <= rd_addr_a;
        rd_b_addr_reg <= rd_addr_b;
        fwd_addr_reg  <= rd_a_addr_reg;
        fwd_data_reg  <= step_new;

        if (cmd.start)
        begin
            s_reg        <= seed;
            slot_reg     <= position_reg;
            out_addr_reg <= start_addr;
        end
        else
        begin
            if (cmd.sweep_wr)
                s_reg <= WORD_W'(s_reg * SEED_MULT);
            if (cmd.step_rd)
                slot_reg <= wrap_idx({1'b0, slot_reg} + ONE_A);
            if (cmd.out_rd)
                out_addr_reg <= out_addr_adv;
        end

        if (cmd.cap_lo)
        begin
            cap_reg[0]    <= rdata_a_reg;
            cap_reg[1]    <= rdata_b_reg;
            cap_count_reg <= COUNT_FOUR;
        end
        if (cmd.cap_hi)
        begin
            cap_reg[2] <= rdata_a_reg;
            cap_reg[3] <= rdata_b_reg;
        end
        if (cmd.cap_x)
        begin
            cap_reg[0]    <= x_word;
            cap_reg[1]    <= '0;
            cap_reg[2]    <= '0;
            cap_reg[3]    <= '0;
            cap_count_reg <= COUNT_ONE;
        end

        if (cmd.out_load)
        begin
            word_reg  <= cap_reg;
            count_reg <= cap_count_reg;
        end
    end

    assign word0      = word_reg[0];
    assign word1      = word_reg[1];
    assign word2      = word_reg[2];
    assign word3      = word_reg[3];
    assign word_count = count_reg;

endmodule

// ===== rtl/core/shift_xor_word_generator_top.sv =====
// ----------------------------------------------------------------------------
// shift_xor_word_generator_top
// Shift/xor recurrence word generator over a ring of 32-bit words.
// ----------------------------------------------------------------------------
// After reset the ring is cleared, during which in_ready stays low
// (configuration writes are taken). A next-32 transaction performs one
// recurrence step, and a next-128 transaction reads its four output words
// and then performs one recurrence step per output word; a seed transaction
// sweeps the ring and the carry word one per cycle. The single write port
// of the ring memory shapes these sequences: each recurrence step and each
// seed word needs one write, and the four output words of a next-128
// transaction are read through the two read ports before any step writes.
// Writing mid_offset with a value at or above RING_WORDS holds in_ready low
// while the offset is reduced. A finished result waits in the output
// register; the next transaction is accepted meanwhile and only stalls
// once its own result is ready.
// ----------------------------------------------------------------------------
module shift_xor_word_generator_top
    import swg_pkg::*;
#(
    parameter int RING_WORDS = 624
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input transaction
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    input  logic [WORD_W-1:0]    seed,
    input  logic [1:0]           word_offset,
    // result transaction
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [WORD_W-1:0]    word0,
    output logic [WORD_W-1:0]    word1,
    output logic [WORD_W-1:0]    word2,
    output logic [WORD_W-1:0]    word3,
    output logic [COUNT_W-1:0]   word_count,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    swg_cmd_t    cmd;
    swg_status_t status;

    // sequencing only; no data passes through the controller
    swg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // ring memory, recurrence logic and output register
    swg_datapath #(
        .RING_WORDS (RING_WORDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .seed        (seed),
        .word_offset (word_offset),
        .cmd         (cmd),
        .status      (status),
        .word0       (word0),
        .word1       (word1),
        .word2       (word2),
        .word3       (word3),
        .word_count  (word_count)
    );

endmodule
